// ===== sv/frc_pkg.sv =====
package frc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  typedef enum logic [5:0] {
    PH_HEAD = 6'b000001,
    PH_LEN0 = 6'b000010,
    PH_LEN1 = 6'b000100,
    PH_BODY = 6'b001000,
    PH_CRC0 = 6'b010000,
    PH_CRC1 = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        frame_end;
    logic        crc_ok;
    logic [15:0] frame_length;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((crc & CRC_TOP) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== sv/frc_cfg.sv =====
module frc_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        ignore_crc
);

  logic sel_ignore;

  assign pready     = 1'b1;
  assign sel_ignore = (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_crc <= 1'b0;
    end else if (psel && penable && pwrite && sel_ignore) begin
      ignore_crc <= pwdata[0];
    end
  end

  assign prdata = sel_ignore ? {31'd0, ignore_crc} : 32'd0;

endmodule

// ===== sv/frc_deframer.sv =====
module frc_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        byte_in,
  input  logic              ignore_crc,
  output logic              res_valid,
  output frc_pkg::result_t  res
);

  frc_pkg::phase_t phase, phase_next;
  logic [15:0] body_remaining, body_remaining_next;
  logic [15:0] length_value, length_value_next;
  logic [15:0] crc_accumulator, crc_accumulator_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] rx_crc;

  assign crc_upd  = frc_pkg::crc_byte(crc_accumulator, byte_in);
  assign len_full = {byte_in, length_value[7:0]};
  assign rx_crc   = {byte_in, crc_low_byte};

  always_comb begin
    phase_next           = phase;
    body_remaining_next  = body_remaining;
    length_value_next    = length_value;
    crc_accumulator_next = crc_accumulator;
    crc_low_byte_next    = crc_low_byte;
    res_valid            = 1'b0;
    res                  = '0;
    unique case (phase)
      frc_pkg::PH_LEN0: begin
        crc_accumulator_next = crc_upd;
        length_value_next    = {8'h00, byte_in};
        phase_next           = frc_pkg::PH_LEN1;
      end
      frc_pkg::PH_LEN1: begin
        crc_accumulator_next = crc_upd;
        length_value_next    = len_full;
        body_remaining_next  = len_full;
        phase_next           = (len_full == 16'd0) ? frc_pkg::PH_CRC0 : frc_pkg::PH_BODY;
      end
      frc_pkg::PH_BODY: begin
        crc_accumulator_next = crc_upd;
        body_remaining_next  = body_remaining - 16'd1;
        if (body_remaining == 16'd1) begin
          phase_next = frc_pkg::PH_CRC0;
        end
        res_valid      = 1'b1;
        res.body_valid = 1'b1;
        res.body_byte  = byte_in;
      end
      frc_pkg::PH_CRC0: begin
        crc_low_byte_next = byte_in;
        phase_next        = frc_pkg::PH_CRC1;
      end
      frc_pkg::PH_CRC1: begin
        res_valid        = 1'b1;
        res.frame_end    = 1'b1;
        res.crc_ok       = (rx_crc == crc_accumulator) || ignore_crc;
        res.frame_length = length_value;
        phase_next       = frc_pkg::PH_HEAD;
      end
      default: begin
        crc_accumulator_next = frc_pkg::crc_byte(16'h0000, byte_in);
        length_value_next    = 16'd0;
        body_remaining_next  = 16'd0;
        crc_low_byte_next    = 8'd0;
        phase_next           = frc_pkg::PH_LEN0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= frc_pkg::PH_HEAD;
      body_remaining  <= 16'd0;
      length_value    <= 16'd0;
      crc_accumulator <= 16'd0;
      crc_low_byte    <= 8'd0;
    end else if (go) begin
      phase           <= phase_next;
      body_remaining  <= body_remaining_next;
      length_value    <= length_value_next;
      crc_accumulator <= crc_accumulator_next;
      crc_low_byte    <= crc_low_byte_next;
    end
  end

endmodule

// ===== sv/frc_out_stage.sv =====
module frc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  frc_pkg::result_t  res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              room,
  output frc_pkg::result_t  out_res
);

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      out_res <= res;
    end
  end

endmodule

// ===== sv/frame_receive_crc16_check.sv =====
// Channel   Handshake                Payload
// input     in_valid / in_stall      rx_byte
// output    out_valid / out_stall    body_valid, body_byte, frame_end, crc_ok, frame_length
// config    psel, penable, pwrite    paddr, pwdata, prdata, pready
//
// One byte is taken per cycle while in_stall is low; a byte passes an input register,
// then the framing state and CRC update, which load the result register, from which
// the result is offered on out_valid.
// The CRC-16 byte update is the longest path.
// Reset returns the receiver to waiting for a head byte and empties both registers.
// A stall on the output holds the result and, through the input register, the input.
module frame_receive_crc16_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        body_valid,
  output logic [7:0]  body_byte,
  output logic        frame_end,
  output logic        crc_ok,
  output logic [15:0] frame_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic             room;
  logic             go;
  logic             ignore_crc;
  logic             res_valid;
  frc_pkg::result_t res;
  frc_pkg::result_t out_res;

  assign go       = in_full && room;
  assign in_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  frc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ignore_crc (ignore_crc)
  );

  frc_deframer u_deframer (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .byte_in    (in_byte),
    .ignore_crc (ignore_crc),
    .res_valid  (res_valid),
    .res        (res)
  );

  frc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (go && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .room      (room),
    .out_res   (out_res)
  );

  assign body_valid   = out_res.body_valid;
  assign body_byte    = out_res.body_byte;
  assign frame_end    = out_res.frame_end;
  assign crc_ok       = out_res.crc_ok;
  assign frame_length = out_res.frame_length;

endmodule
